// ===== hdl/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg
// Types, limits and the month-length table for the calendar clock.
// ----------------------------------------------------------------------------
package cct_pkg;

  // Field widths
  localparam int unsigned WdayW = 3;
  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 7;
  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned SecW  = 6;

  // Packed time word width, padded up to whole bytes on the bus
  localparam int unsigned TimeW = WdayW + DayW + MonW + YearW + HourW + MinW + SecW;
  localparam int unsigned BusW  = ((TimeW + 7) / 8) * 8;

  // Top values at which each counter rolls over
  localparam logic [SecW-1:0]  SecTop  = SecW'(59);
  localparam logic [MinW-1:0]  MinTop  = MinW'(59);
  localparam logic [HourW-1:0] HourTop = HourW'(23);
  localparam logic [WdayW-1:0] WdayTop = WdayW'(6);
  localparam logic [MonW-1:0]  MonTop  = MonW'(12);
  localparam logic [YearW-1:0] YearTop = YearW'(99);
  localparam logic [MonW-1:0]  MonFeb  = MonW'(2);

  // Reset time: Saturday, January 1st, year 0, midnight
  localparam logic [DayW-1:0]  DayFirst = DayW'(1);
  localparam logic [MonW-1:0]  MonFirst = MonW'(1);

  // Item kind carried on tuser
  typedef enum logic {
    ReqTick = 1'b0,
    ReqLoad = 1'b1
  } req_e;

  // Complete time of day and date
  typedef struct packed {
    logic [WdayW-1:0] weekday;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } cct_time_t;

  localparam cct_time_t TimeReset = '{
    weekday: '0, day: DayFirst, month: MonFirst, year: '0,
    hour: '0, minute: '0, second: '0
  };

  // Days in a month; codes 0 and 13..15 count as 31 days
  function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] month,
                                                 input logic [YearW-1:0] year);
    logic [DayW-1:0] len;
    case (month)
      4'd2:                  len = DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DayW'(30);
      default:               len = DayW'(31);
    endcase
    // leap February every fourth year
    if (month == MonFeb && year[1:0] == 2'b00) begin
      len = DayW'(29);
    end
    return len;
  endfunction

endpackage

// ===== hdl/calendar_clock_tick.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_tick
// Real-time clock with calendar; each item ticks one second or loads the time.
// ----------------------------------------------------------------------------
// An accepted item passes the input register, then the time register, which
// drives the result word; a full result slot holds it in the input register.
// Throughput: one item per cycle unless the result side stalls; the input
// register feeds the next-time logic, whose result lands in the time register that drives tdata.
// Reset: asynchronous, active low; both sides empty, time set to Saturday,
// day 1, month 1, year 0, 00:00:00.
module calendar_clock_tick
  import cct_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // input side
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // tdata: load_weekday, load_day, load_month, load_year,
  //        load_hour, load_minute, load_second, zero pad
  input  logic [BusW-1:0] s_axis_tdata,
  // tuser: req_type
  input  logic            s_axis_tuser,
  // result side
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // tdata: weekday, day, month, year, hour, minute, second, zero pad
  output logic [BusW-1:0] m_axis_tdata
);

  localparam int unsigned PadW = BusW - TimeW;

  logic      in_valid_q;
  logic      in_valid_d;
  req_e      req_q;
  cct_time_t load_q;
  cct_time_t load_in;
  logic      out_valid_q;
  logic      out_valid_d;
  cct_time_t time_q;
  cct_time_t time_d;
  logic      advance;
  logic      in_take;

  // Unpack the input word, lowest field first
  assign load_in.weekday = s_axis_tdata[2:0];
  assign load_in.day     = s_axis_tdata[7:3];
  assign load_in.month   = s_axis_tdata[11:8];
  assign load_in.year    = s_axis_tdata[18:12];
  assign load_in.hour    = s_axis_tdata[23:19];
  assign load_in.minute  = s_axis_tdata[29:24];
  assign load_in.second  = s_axis_tdata[35:30];

  // Handshake: item moves on when the result slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  // Next time from the held item
  cct_next u_next (
    .cur_i  (time_q),
    .req_i  (req_q),
    .load_i (load_q),
    .nxt_o  (time_d)
  );

  // Control and time registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      time_q      <= TimeReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        time_q <= time_d;
      end
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q  <= req_e'(s_axis_tuser);
      load_q <= load_in;
    end
  end

  // Result word: the time register itself
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, time_q.second, time_q.minute, time_q.hour,
                          time_q.year, time_q.month, time_q.day, time_q.weekday};

`ifndef NO_ASSERTIONS
  // Time only changes when an item moves into the result slot
  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(time_q))
    else $error("time changed without an item");

  // A held item with a free result slot always moves on
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("item stuck in input register");

  // A load takes every field as given
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && req_q == ReqLoad) |=> time_q == $past(load_q))
    else $error("load not applied");

  // A tick below the minute boundary only bumps the second
  a_tick_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && req_q == ReqTick && time_q.second < SecTop) |=>
      (time_q.second == $past(time_q.second) + SecW'(1)) &&
      (time_q.minute == $past(time_q.minute)))
    else $error("second tick wrong");
`endif

endmodule

// ===== hdl/cct_next.sv =====
// ----------------------------------------------------------------------------
// cct_next
// Next-time logic: one-second advance with cascaded rollover, or load.
// ----------------------------------------------------------------------------
module cct_next
  import cct_pkg::*;
(
  input  cct_time_t cur_i,
  input  req_e      req_i,
  input  cct_time_t load_i,
  output cct_time_t nxt_o
);

  logic            sec_wrap;
  logic            min_wrap;
  logic            hour_wrap;
  logic            month_end;
  logic [DayW-1:0] dim;
  cct_time_t       tick;

  assign sec_wrap  = (cur_i.second >= SecTop);
  assign min_wrap  = (cur_i.minute >= MinTop);
  assign hour_wrap = (cur_i.hour >= HourTop);
  assign dim       = month_days(cur_i.month, cur_i.year);
  assign month_end = (cur_i.day >= dim);

  // Cascaded second / minute / hour / date advance
  always_comb begin
    tick = cur_i;
    if (!sec_wrap) begin
      tick.second = cur_i.second + SecW'(1);
    end else begin
      tick.second = '0;
      if (!min_wrap) begin
        tick.minute = cur_i.minute + MinW'(1);
      end else begin
        tick.minute = '0;
        if (!hour_wrap) begin
          tick.hour = cur_i.hour + HourW'(1);
        end else begin
          // midnight: new day
          tick.hour    = '0;
          tick.weekday = (cur_i.weekday >= WdayTop) ? '0 : cur_i.weekday + WdayW'(1);
          if (!month_end) begin
            tick.day = cur_i.day + DayW'(1);
          end else begin
            tick.day = DayFirst;
            if (cur_i.month >= MonTop) begin
              tick.month = MonFirst;
              tick.year  = (cur_i.year >= YearTop) ? '0 : cur_i.year + YearW'(1);
            end else begin
              tick.month = cur_i.month + MonW'(1);
            end
          end
        end
      end
    end
  end

  assign nxt_o = (req_i == ReqLoad) ? load_i : tick;

endmodule
